### rtl/core/stt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, character codes and token kinds for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	typedef logic [4:0] kind_t;

	localparam kind_t KIND_ILLEGAL   = 5'd0;
	localparam kind_t KIND_END       = 5'd1;
	localparam kind_t KIND_IDENT     = 5'd2;
	localparam kind_t KIND_INT       = 5'd3;
	localparam kind_t KIND_ASSIGN    = 5'd4;
	localparam kind_t KIND_EQUAL     = 5'd5;
	localparam kind_t KIND_BANG      = 5'd6;
	localparam kind_t KIND_NOT_EQUAL = 5'd7;
	localparam kind_t KIND_PLUS      = 5'd8;
	localparam kind_t KIND_MINUS     = 5'd9;
	localparam kind_t KIND_STAR      = 5'd10;
	localparam kind_t KIND_SLASH     = 5'd11;
	localparam kind_t KIND_LT        = 5'd12;
	localparam kind_t KIND_GT        = 5'd13;
	localparam kind_t KIND_COMMA     = 5'd14;
	localparam kind_t KIND_SEMICOLON = 5'd15;
	localparam kind_t KIND_LPAREN    = 5'd16;
	localparam kind_t KIND_RPAREN    = 5'd17;
	localparam kind_t KIND_LBRACE    = 5'd18;
	localparam kind_t KIND_RBRACE    = 5'd19;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam int QDEPTH = 4;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_EQ    = 3'd1,
		MODE_BANG  = 3'd2,
		MODE_IDENT = 3'd3,
		MODE_INT   = 3'd4
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  bad;
	} tok_t;

	// One accepted byte's results: tok0 always, tok1 only when two is set.
	typedef struct packed {
		logic two;
		tok_t tok0;
		tok_t tok1;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z], CH_US});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {[CH_0:CH_9]});
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR});
	endfunction

	function automatic kind_t op_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_STAR:   k = KIND_STAR;
			CH_SLASH:  k = KIND_SLASH;
			CH_LT:     k = KIND_LT;
			CH_GT:     k = KIND_GT;
			CH_COMMA:  k = KIND_COMMA;
			CH_SEMI:   k = KIND_SEMICOLON;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			default:   k = KIND_ILLEGAL;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

### rtl/core/stt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_front
// Scanner: accepts one byte a cycle while accept is high, tracks the pending run
// and builds the record of tokens the byte causes.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] text_byte,
	output logic            push,
	output rec_t            push_rec
);

	typedef logic [OFFSET_BITS-1:0] ofs_t;

	mode_t mode_q, mode_nx;
	ofs_t  offset_q, offset_nx;
	ofs_t  run_q, run_nx;
	ofs_t  pos_next;
	ofs_t  run_len;

	logic  flush_v, own_v;
	tok_t  flush_tok, own_tok;

	function automatic logic [15:0] sat16(input ofs_t v);
		logic [15:0] r;
		if (OFFSET_BITS > 16 && (v >> 16) != '0) begin
			r = '1;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

	assign pos_next = (offset_q == '1) ? offset_q : offset_q + 1'b1;
	assign run_len  = offset_q - run_q;

	// Next state
	always_comb begin
		mode_nx   = mode_q;
		offset_nx = pos_next;
		run_nx    = run_q;
		case (mode_q)
			MODE_IDENT: begin
				if (!is_letter(text_byte)) begin
					mode_nx = MODE_IDLE;
				end
			end
			MODE_INT: begin
				if (!is_digit(text_byte)) begin
					mode_nx = MODE_IDLE;
				end
			end
			default: begin
				mode_nx = MODE_IDLE;
			end
		endcase
		// a byte that neither continues a run nor completes a pair starts fresh
		if (mode_nx == MODE_IDLE &&
		    !((mode_q == MODE_EQ || mode_q == MODE_BANG) && text_byte == CH_EQ)) begin
			if (text_byte == CH_NUL) begin
				offset_nx = '0;
				run_nx    = '0;
			end else if (text_byte == CH_EQ) begin
				mode_nx = MODE_EQ;
				run_nx  = offset_q;
			end else if (text_byte == CH_BANG) begin
				mode_nx = MODE_BANG;
				run_nx  = offset_q;
			end else if (is_letter(text_byte)) begin
				mode_nx = MODE_IDENT;
				run_nx  = offset_q;
			end else if (is_digit(text_byte)) begin
				mode_nx = MODE_INT;
				run_nx  = offset_q;
			end
		end
	end

	// Outputs
	always_comb begin
		logic pair_done;
		logic own_allowed;
		pair_done       = 1'b0;
		own_allowed     = 1'b1;
		flush_v         = 1'b0;
		flush_tok       = '0;
		flush_tok.start = sat16(run_q);
		own_v           = 1'b0;
		own_tok         = '0;
		own_tok.start   = sat16(offset_q);
		case (mode_q)
			MODE_EQ, MODE_BANG: begin
				flush_v = 1'b1;
				if (text_byte == CH_EQ) begin
					pair_done        = 1'b1;
					flush_tok.kind   = (mode_q == MODE_EQ) ? KIND_EQUAL : KIND_NOT_EQUAL;
					flush_tok.length = 16'd2;
				end else begin
					flush_tok.kind   = (mode_q == MODE_EQ) ? KIND_ASSIGN : KIND_BANG;
					flush_tok.length = 16'd1;
				end
			end
			MODE_IDENT: begin
				if (is_letter(text_byte)) begin
					own_allowed = 1'b0;
				end else begin
					flush_v          = 1'b1;
					flush_tok.kind   = KIND_IDENT;
					flush_tok.length = sat16(run_len);
				end
			end
			MODE_INT: begin
				if (is_digit(text_byte)) begin
					own_allowed = 1'b0;
				end else begin
					flush_v          = 1'b1;
					flush_tok.kind   = KIND_INT;
					flush_tok.length = sat16(run_len);
				end
			end
			default: begin
			end
		endcase
		if (own_allowed && !pair_done) begin
			if (text_byte == CH_NUL) begin
				own_v          = 1'b1;
				own_tok.kind   = KIND_END;
				own_tok.length = 16'd0;
			end else if (!is_space(text_byte) && text_byte != CH_EQ &&
			             text_byte != CH_BANG && !is_letter(text_byte) &&
			             !is_digit(text_byte)) begin
				own_v          = 1'b1;
				own_tok.kind   = op_kind(text_byte);
				own_tok.length = 16'd1;
				own_tok.bad    = (op_kind(text_byte) == KIND_ILLEGAL) ? text_byte : 8'd0;
			end
		end
	end

	assign push          = accept && (flush_v || own_v);
	assign push_rec.two  = flush_v && own_v;
	assign push_rec.tok0 = flush_v ? flush_tok : own_tok;
	assign push_rec.tok1 = own_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			offset_q <= '0;
			run_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_nx;
			offset_q <= offset_nx;
			run_q    <= run_nx;
		end
	end

endmodule
`default_nettype wire

### rtl/core/stt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_queue
// Short record queue between the scanner and the token sender.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  rec_t      push_rec,
	input  wire logic pop,
	output rec_t      head,
	output qstat_t    stat
);

	localparam int PTR_W = $clog2(QDEPTH);

	rec_t             entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign stat.full  = (count_q == (PTR_W+1)'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/stt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_back
// Token sender: unpacks queued records into single tokens on the output
// register, one per cycle while token_stall is low.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  rec_t        head,
	input  qstat_t      stat,
	output logic        pop,
	output logic        token_valid,
	input  wire logic   token_stall,
	output logic [4:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [7:0]  illegal_byte,
	output logic        last_of_item
);

	logic out_valid_q;
	tok_t out_tok_q;
	logic out_last_q;
	logic sec_valid_q;
	tok_t sec_tok_q;
	logic load;

	assign load = !out_valid_q || !token_stall;
	assign pop  = load && !sec_valid_q && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (load) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else begin
				out_valid_q <= !stat.empty;
				sec_valid_q <= !stat.empty && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sec_valid_q) begin
				out_tok_q  <= sec_tok_q;
				out_last_q <= 1'b1;
			end else begin
				// hold the second token of a pair until the first has gone
				out_tok_q  <= head.tok0;
				out_last_q <= !head.two;
				sec_tok_q  <= head.tok1;
			end
		end
	end

	assign token_valid  = out_valid_q;
	assign token_kind   = out_tok_q.kind;
	assign token_start  = out_tok_q.start;
	assign token_length = out_tok_q.length;
	assign illegal_byte = out_tok_q.bad;
	assign last_of_item = out_last_q;

endmodule
`default_nettype wire

### rtl/core/source_text_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Splits a byte stream of source text into tokens, one byte per item in.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  text    | text_valid / text_stall   | text_byte
//  token   | token_valid / token_stall | token_kind, token_start, token_length,
//          |                           | illegal_byte, last_of_item
//
// One byte is taken every cycle while the record queue (4 entries) has room.
// Each token leaves through the output register at one per cycle while token_stall
// is low; a byte that causes two tokens takes an output slot for each, absorbed by the queue.
// With no stall, a byte's first token is written to a queue entry and then loaded
// into the output register.
// Reset clears the scan position, pending run and queue; text_stall is high
// exactly while the queue is full.
// ----------------------------------------------------------------------------
module source_text_tokenizer import stt_pkg::*; #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        text_valid,
	output logic             text_stall,
	input  wire logic [7:0]  text_byte,
	output logic             token_valid,
	input  wire logic        token_stall,
	output logic [4:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic [7:0]       illegal_byte,
	output logic             last_of_item
);

	logic   accept;
	logic   push;
	rec_t   push_rec;
	logic   pop;
	rec_t   head;
	qstat_t stat;

	assign text_stall = stat.full;
	assign accept     = text_valid && !stat.full;

	stt_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.text_byte(text_byte),
		.push     (push),
		.push_rec (push_rec)
	);

	stt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.head    (head),
		.stat    (stat)
	);

	stt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.illegal_byte(illegal_byte),
		.last_of_item(last_of_item)
	);

endmodule
`default_nettype wire
